// ===== hw/rtl/kdoc_pkg.sv =====
// Shared types and constants for the k-mer dyad occurrence counter.
package kdoc_pkg;

  typedef enum logic [1:0] {
    REQ_BASE = 2'd0,
    REQ_NEWSEQ = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_OLIGO = 3'd0,
    REG_DYAD = 3'd1,
    REG_GAP = 3'd2,
    REG_BOTH = 3'd3,
    REG_NOOVL = 3'd4,
    REG_GROUP = 3'd5
  } reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ENCODE,
    ST_RD1,
    ST_RD1W,
    ST_DECIDE,
    ST_WR1,
    ST_RD2,
    ST_RD2W,
    ST_WR2,
    ST_READQ,
    ST_READW,
    ST_OUT
  } state_t;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Returns {valid, code}.
  function automatic logic [2:0] encode_base(input logic [7:0] c);
    logic [7:0] u;
    u = c & ~CASE_BIT;
    if (c == u || (c | CASE_BIT) == c) begin
      if (u == CH_A) return 3'b100;
      if (u == CH_C) return 3'b101;
      if (u == CH_G) return 3'b110;
      if (u == CH_T) return 3'b111;
    end
    return 3'b000;
  endfunction

endpackage

// ===== hw/rtl/kdoc_ram.sv =====
// Generic single-port RAM with registered read.
module kdoc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/kmer_dyad_occurrence_counter.sv =====
// Top level of the k-mer dyad occurrence counter.
// One beat is taken at a time: s_tready is high only while the sequencer idles. Each
// counted base beat runs a read-modify-write sequence that shares one address over the
// occurrence, overlap and last-start tables. Words are formed combinationally from the
// window taps. A base beat passes the encode state and, if a window is counted, the read,
// decide and write states for one entry, and the read and write states again if the other
// strand is updated too. A read beat passes the read-request and read-wait states; an
// unused request type goes straight to the output state. After reset, and for each
// new-sequence beat, a clearing pass over all 4^MAX_MOTIF table entries (65536 by
// default) runs with s_tready low; the pass after reset clears all three tables and gives
// no result, a new sequence clears only the last-start table and its result follows the
// pass. Results wait in an output register, so the next beat is taken and worked on while
// one waits; the sequencer then holds in its last state until the register is free.
module kmer_dyad_occurrence_counter #(
  parameter int MAX_MOTIF = 8,
  parameter int MAX_GAP = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // base_char[7:0], entry_index[23:8]
  input  logic [1:0]   s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,   // word_index, was_overlap, occ_count, overlap_count,
                                  // positions_total, counted_total, config_error
  output logic         m_tuser,   // window_counted
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int WIN = MAX_MOTIF + MAX_GAP;
  localparam int IB = 2 * MAX_MOTIF;
  localparam int TSZ = 1 << IB;
  localparam int WB = $clog2(WIN);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  // configuration
  logic [3:0] oligo_len;
  logic dyad_mode, both_strands, no_overlap, group_strands;
  logic [4:0] gap_len;
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      oligo_len <= 4'd6; dyad_mode <= 1'b0; gap_len <= 5'd0;
      both_strands <= 1'b0; no_overlap <= 1'b0; group_strands <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        kdoc_pkg::REG_OLIGO: oligo_len <= pwdata[3:0];
        kdoc_pkg::REG_DYAD: dyad_mode <= pwdata[0];
        kdoc_pkg::REG_GAP: gap_len <= pwdata[4:0];
        kdoc_pkg::REG_BOTH: both_strands <= pwdata[0];
        kdoc_pkg::REG_NOOVL: no_overlap <= pwdata[0];
        kdoc_pkg::REG_GROUP: group_strands <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      kdoc_pkg::REG_OLIGO: prdata = {28'd0, oligo_len};
      kdoc_pkg::REG_DYAD: prdata = {31'd0, dyad_mode};
      kdoc_pkg::REG_GAP: prdata = {27'd0, gap_len};
      kdoc_pkg::REG_BOTH: prdata = {31'd0, both_strands};
      kdoc_pkg::REG_NOOVL: prdata = {31'd0, no_overlap};
      kdoc_pkg::REG_GROUP: prdata = {31'd0, group_strands};
      default: prdata = '0;
    endcase
  end

  // derived lengths
  logic [4:0] motif;
  logic [5:0] gap, full;
  logic err;
  assign motif = dyad_mode ? {oligo_len, 1'b0} : {1'b0, oligo_len};
  assign gap = dyad_mode ? {1'b0, gap_len} : 6'd0;
  assign full = {1'b0, motif} + gap;
  assign err = (oligo_len == 4'd0) || (32'(motif) > MAX_MOTIF) ||
               (dyad_mode && 32'(gap_len) > MAX_GAP);

  // state
  kdoc_pkg::state_t state, state_next;
  logic [2:0] win [WIN];
  logic [31:0] seq_position, positions_counter, counted_counter;
  logic [IB-1:0] clr_addr;
  logic [IB-1:0] idx, other;
  logic do_other, ovl;
  logic [31:0] start;
  logic [15:0] eidx;
  logic [IB-1:0] eidx_w;

  // working result
  logic r_cnt, r_ovl;
  logic [15:0] r_widx;
  logic [31:0] r_occ, r_ovc;

  // memories
  logic occ_we, ovt_we, ls_we;
  logic [IB-1:0] taddr;
  logic [COUNT_BITS-1:0] occ_rd, ovt_rd, occ_wd, ovt_wd;
  logic [32:0] ls_rd, ls_wd;

  kdoc_ram #(.WIDTH(COUNT_BITS), .DEPTH(TSZ)) u_occ (
    .clk, .we(occ_we), .addr(taddr), .wdata(occ_wd), .rdata(occ_rd));
  kdoc_ram #(.WIDTH(COUNT_BITS), .DEPTH(TSZ)) u_ovt (
    .clk, .we(ovt_we), .addr(taddr), .wdata(ovt_wd), .rdata(ovt_rd));
  kdoc_ram #(.WIDTH(33), .DEPTH(TSZ)) u_ls (
    .clk, .we(ls_we), .addr(taddr), .wdata(ls_wd), .rdata(ls_rd));

  // occ/overlap tables need a clear after reset too; one pass clears all three
  logic clr_tables;

  // word formation from window taps
  logic [IB-1:0] fw, rw;
  logic ok_c;
  always_comb begin
    logic [5:0] off, age;
    logic [2:0] b;
    fw = '0; rw = '0; ok_c = 1'b1;
    for (int o = 0; o < MAX_MOTIF; o++) begin
      off = (6'(o) < {2'b0, oligo_len}) ? 6'(o) : 6'(o) + gap;
      age = full - 6'd1 - off;
      b = (32'(age) < WIN) ? win[WB'(age)] : win[0];
      if (5'(o) < motif) begin
        if (!b[2]) ok_c = 1'b0;
        fw = {fw[IB-3:0], b[1:0]};
      end
    end
    for (int o = MAX_MOTIF - 1; o >= 0; o--) begin
      off = (6'(o) < {2'b0, oligo_len}) ? 6'(o) : 6'(o) + gap;
      age = full - 6'd1 - off;
      b = (32'(age) < WIN) ? win[WB'(age)] : win[0];
      if (5'(o) < motif) rw = {rw[IB-3:0], 2'd3 - b[1:0]};
    end
  end

  assign s_tready = (state == kdoc_pkg::ST_IDLE);
  logic acc, out_free;
  assign acc = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      kdoc_pkg::ST_IDLE:
        if (acc) begin
          if (s_tuser == kdoc_pkg::REQ_BASE) state_next = kdoc_pkg::ST_ENCODE;
          else if (s_tuser == kdoc_pkg::REQ_NEWSEQ) state_next = kdoc_pkg::ST_CLEAR;
          else if (s_tuser == kdoc_pkg::REQ_READ) state_next = kdoc_pkg::ST_READQ;
          else state_next = kdoc_pkg::ST_OUT;
        end
      kdoc_pkg::ST_CLEAR:
        if (clr_addr == '1) state_next = clr_tables ? kdoc_pkg::ST_IDLE : kdoc_pkg::ST_OUT;
      kdoc_pkg::ST_ENCODE:
        state_next = (!err && ok_c) ? kdoc_pkg::ST_RD1 : kdoc_pkg::ST_OUT;
      kdoc_pkg::ST_RD1: state_next = kdoc_pkg::ST_RD1W;
      kdoc_pkg::ST_RD1W: state_next = kdoc_pkg::ST_DECIDE;
      kdoc_pkg::ST_DECIDE: state_next = kdoc_pkg::ST_WR1;
      kdoc_pkg::ST_WR1: state_next = do_other ? kdoc_pkg::ST_RD2 : kdoc_pkg::ST_OUT;
      kdoc_pkg::ST_RD2: state_next = kdoc_pkg::ST_RD2W;
      kdoc_pkg::ST_RD2W: state_next = kdoc_pkg::ST_WR2;
      kdoc_pkg::ST_WR2: state_next = kdoc_pkg::ST_OUT;
      kdoc_pkg::ST_READQ: state_next = kdoc_pkg::ST_READW;
      kdoc_pkg::ST_READW: state_next = kdoc_pkg::ST_OUT;
      kdoc_pkg::ST_OUT: state_next = out_free ? kdoc_pkg::ST_IDLE : kdoc_pkg::ST_OUT;
      default: state_next = kdoc_pkg::ST_IDLE;
    endcase
  end

  assign eidx_w = IB'(eidx);

  // memory control
  always_comb begin
    occ_we = 1'b0; ovt_we = 1'b0; ls_we = 1'b0;
    taddr = idx;
    occ_wd = (occ_rd != CMAX) ? occ_rd + COUNT_BITS'(1) : occ_rd;
    ovt_wd = (ovt_rd != CMAX) ? ovt_rd + COUNT_BITS'(1) : ovt_rd;
    ls_wd = {1'b1, start};
    unique case (state)
      kdoc_pkg::ST_CLEAR: begin
        taddr = clr_addr; ls_we = 1'b1; ls_wd = '0;
        occ_we = clr_tables; ovt_we = clr_tables;
        occ_wd = '0; ovt_wd = '0;
      end
      kdoc_pkg::ST_WR1: begin
        occ_we = !ovl; ovt_we = ovl; ls_we = !ovl && no_overlap;
      end
      kdoc_pkg::ST_RD2, kdoc_pkg::ST_RD2W: taddr = other;
      kdoc_pkg::ST_WR2: begin
        taddr = other; occ_we = !ovl; ovt_we = ovl;
      end
      kdoc_pkg::ST_READQ, kdoc_pkg::ST_READW: taddr = eidx_w;
      default: ;
    endcase
  end

  logic eidx_in;
  assign eidx_in = (MAX_MOTIF >= 8) || (eidx >> IB) == 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kdoc_pkg::ST_CLEAR;
      clr_addr <= '0;
      clr_tables <= 1'b1;
      for (int i = 0; i < WIN; i++) win[i] <= 3'b000;
      seq_position <= '0;
      positions_counter <= '0;
      counted_counter <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // output register loads when free, else drains on the handshake
      if (state == kdoc_pkg::ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
        m_tuser <= r_cnt;
        m_tdata <= {6'd0, err, counted_counter, positions_counter, r_ovc, r_occ,
                    r_ovl, r_widx};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        kdoc_pkg::ST_IDLE:
          if (acc) begin
            eidx <= s_tdata[23:8];
            r_cnt <= 1'b0; r_ovl <= 1'b0; r_widx <= '0; r_occ <= '0; r_ovc <= '0;
            if (s_tuser == kdoc_pkg::REQ_NEWSEQ) begin
              clr_addr <= '0; clr_tables <= 1'b0;
              for (int i = 0; i < WIN; i++) win[i] <= 3'b000;
              seq_position <= '0;
            end
            if (s_tuser == kdoc_pkg::REQ_BASE) begin
              win[0] <= kdoc_pkg::encode_base(s_tdata[7:0]);
              for (int i = 1; i < WIN; i++) win[i] <= win[i-1];
              seq_position <= seq_position + 32'd1;
            end
          end
        kdoc_pkg::ST_CLEAR: clr_addr <= clr_addr + IB'(1);
        kdoc_pkg::ST_ENCODE: begin
          idx <= (both_strands && rw < fw) ? rw : fw;
          other <= (rw < fw) ? fw : rw;
          do_other <= both_strands && !group_strands && rw != fw;
          start <= seq_position - 32'(full);
        end
        kdoc_pkg::ST_RD1W: begin
          r_cnt <= 1'b1;
          r_widx <= 16'(idx);
          if (positions_counter != '1) positions_counter <= positions_counter + 32'd1;
        end
        kdoc_pkg::ST_DECIDE: begin
          ovl <= no_overlap && ls_rd[32] && (start - ls_rd[31:0]) < 32'(full);
          r_ovl <= no_overlap && ls_rd[32] && (start - ls_rd[31:0]) < 32'(full);
        end
        kdoc_pkg::ST_WR1:
          if (!ovl && counted_counter != '1) counted_counter <= counted_counter + 32'd1;
        kdoc_pkg::ST_READW:
          if (eidx_in) begin
            r_occ <= 32'(occ_rd); r_ovc <= 32'(ovt_rd);
          end
        default: ;
      endcase
    end
  end
endmodule

// ===== hw/rtl/kdoc_checker.sv =====
// Port-level assertions for the k-mer dyad occurrence counter, bound to the top level.
module kdoc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [151:0] m_tdata,
  input logic         m_tuser
);
  // one beat at a time: never ready in the cycle after acceptance
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");
  // no overlap flag without a counted window
  a_ovl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] |-> m_tuser) else $error("overlap without window");
  // positions total never decreases across delivered beats
  a_tot: assert property (@(posedge clk) disable iff (rst)
    $past(m_tvalid) && m_tvalid && !$past(rst) |-> m_tdata[112:81] >= $past(m_tdata[112:81]))
    else $error("positions total fell");
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");
endmodule

bind kmer_dyad_occurrence_counter kdoc_checker u_kdoc_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser);
